// ----- rtl/core/spf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg: shared definitions for the servo packet framer
// Item kinds, protocol constants and the widths of the byte list that one
// input item expands to.
// ----------------------------------------------------------------------------
package spf_pkg;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_PARAM  = 1'b1
  } kind_t;

  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [7:0] BareLen    = 8'd2;
  localparam logic [7:0] LenOffset  = 8'd3;

  // A header with an address and no parameters yields the most bytes.
  localparam int unsigned MaxResults = 7;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam int unsigned InDataW    = 48;

  typedef logic [MaxResults-1:0][7:0] byte_list_t;
  typedef logic [CntW-1:0]            byte_cnt_t;

endpackage : spf_pkg
`default_nettype wire

// ----- rtl/core/servo_packet_framer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// servo_packet_framer: servo-bus instruction packet framer
// Turns header and parameter items into the packet byte stream with checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one item per transfer. tuser selects a header
//   (0) or a parameter byte (1). A header with an address expands to
//   FF FF ID LEN INST ADDR, plus CHK if it announces no parameters, a bare
//   header to FF FF ID 2 INST CHK. Parameter bytes pass through, and the
//   checksum byte, marked by tlast, follows the last announced parameter.
//   Parameter items outside a packet are dropped. The output stream carries
//   one packet byte per transfer. The first byte of an item is valid in the
//   cycle after its transfer. An item yields one byte for a plain parameter,
//   two for the final parameter, six or seven for a header and none for a
//   dropped parameter. These bytes leave one per cycle from a shift register
//   while the receiver is ready, and the next item is taken in the cycle the
//   last of them leaves, so parameter bytes stream at one per cycle.
//   Reset empties the byte buffer and clears the packet state (idle, sum zero).
//   When the receiver stalls, the buffered bytes hold and the input side
//   stops taking items until the final buffered byte leaves.
// ----------------------------------------------------------------------------
module servo_packet_framer (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // servo_id[7:0], instruction[15:8], address[23:16], param_count[31:24],
  // has_address[32], param_byte[40:33], zero fill[47:41]
  input  wire  [spf_pkg::InDataW-1:0] s_axis_tdata,
  // kind[0]
  input  wire                        s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]                 m_axis_tdata,
  output logic                       m_axis_tlast
);
  import spf_pkg::*;

  // Packet state
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic       in_packet, in_packet_next;

  // Output byte list, element 0 is the byte on the bus
  byte_list_t             obuf, ld_bytes;
  logic [MaxResults-1:0]  olast, ld_last;
  byte_cnt_t              ocnt, ld_cnt;

  logic       in_xfer, out_xfer;
  kind_t      in_kind;
  logic [7:0] servo_id, instruction, address, param_count, param_byte;
  logic       has_address;
  logic [7:0] len, hdr_sum, param_sum, rem_dec;

  assign servo_id    = s_axis_tdata[7:0];
  assign instruction = s_axis_tdata[15:8];
  assign address     = s_axis_tdata[23:16];
  assign param_count = s_axis_tdata[31:24];
  assign has_address = s_axis_tdata[32];
  assign param_byte  = s_axis_tdata[40:33];
  assign in_kind     = kind_t'(s_axis_tuser);

  assign m_axis_tvalid = (ocnt != '0);
  assign m_axis_tdata  = obuf[0];
  assign m_axis_tlast  = olast[0];
  assign out_xfer      = m_axis_tvalid & m_axis_tready;

  // Take a new item when the buffer is empty or its final byte leaves now.
  assign s_axis_tready = (ocnt == '0) || ((ocnt == byte_cnt_t'(1)) && m_axis_tready);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  assign len       = has_address ? 8'(param_count + LenOffset) : BareLen;
  assign hdr_sum   = has_address ? 8'(servo_id + len + instruction + address)
                                 : 8'(servo_id + len + instruction);
  assign param_sum = 8'(running_sum + param_byte);
  assign rem_dec   = 8'(bytes_remaining - 8'd1);

  always_comb begin
    ld_bytes             = '0;
    ld_last              = '0;
    ld_cnt               = '0;
    running_sum_next     = running_sum;
    bytes_remaining_next = bytes_remaining;
    in_packet_next       = in_packet;
    unique case (in_kind)
      KIND_HEADER: begin
        ld_bytes[0] = SyncByte;
        ld_bytes[1] = SyncByte;
        ld_bytes[2] = servo_id;
        ld_bytes[3] = len;
        ld_bytes[4] = instruction;
        if (has_address) begin
          ld_bytes[5] = address;
          if (param_count == 8'd0) begin
            ld_bytes[6]          = ~hdr_sum;
            ld_last[6]           = 1'b1;
            ld_cnt               = byte_cnt_t'(7);
            running_sum_next     = '0;
            bytes_remaining_next = '0;
            in_packet_next       = 1'b0;
          end else begin
            ld_cnt               = byte_cnt_t'(6);
            running_sum_next     = hdr_sum;
            bytes_remaining_next = param_count;
            in_packet_next       = 1'b1;
          end
        end else begin
          // A bare instruction packet closes at once.
          ld_bytes[5]          = ~hdr_sum;
          ld_last[5]           = 1'b1;
          ld_cnt               = byte_cnt_t'(6);
          running_sum_next     = '0;
          bytes_remaining_next = '0;
          in_packet_next       = 1'b0;
        end
      end
      KIND_PARAM: begin
        if (in_packet) begin
          ld_bytes[0] = param_byte;
          if (rem_dec == 8'd0) begin
            ld_bytes[1]          = ~param_sum;
            ld_last[1]           = 1'b1;
            ld_cnt               = byte_cnt_t'(2);
            running_sum_next     = '0;
            bytes_remaining_next = '0;
            in_packet_next       = 1'b0;
          end else begin
            ld_cnt               = byte_cnt_t'(1);
            running_sum_next     = param_sum;
            bytes_remaining_next = rem_dec;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      bytes_remaining <= '0;
      in_packet       <= 1'b0;
      ocnt            <= '0;
      olast           <= '0;
    end else begin
      if (in_xfer) begin
        running_sum     <= running_sum_next;
        bytes_remaining <= bytes_remaining_next;
        in_packet       <= in_packet_next;
        ocnt            <= ld_cnt;
        olast           <= ld_last;
      end else if (out_xfer) begin
        ocnt  <= ocnt - byte_cnt_t'(1);
        olast <= olast >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      obuf <= ld_bytes;
    end else if (out_xfer) begin
      obuf <= obuf >> 8;
    end
  end

  // The buffer never holds more than one item's bytes.
  assert property (@(posedge clk) disable iff (rst) ocnt <= byte_cnt_t'(MaxResults))
    else $error("byte count beyond list size");

  // The checksum byte is always the final byte of a list.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (ocnt == byte_cnt_t'(1)))
    else $error("checksum byte not at end of list");

  // An open packet always expects at least one more parameter byte.
  assert property (@(posedge clk) disable iff (rst) in_packet |-> (bytes_remaining != 8'd0))
    else $error("open packet with nothing remaining");

  // A transfer on the input side only happens when the buffer is empty or its final byte leaves in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ((ocnt == '0) || (ocnt == byte_cnt_t'(1) && out_xfer)))
    else $error("item taken while bytes still pending");

endmodule : servo_packet_framer
`default_nettype wire

// ----- tb/tb_servo_packet_framer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_packet_framer: self-checking testbench for the servo packet framer
// Header and parameter items are streamed into the block with random gaps.
// A local model of the framer predicts every packet byte and its end marker,
// and each output transfer is checked against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_servo_packet_framer;
  import spf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAt     = 80;
  localparam int unsigned CalmFrom   = 200;
  localparam int unsigned CalmTo     = 260;
  localparam int unsigned IdlePct    = 14;

  typedef struct {
    kind_t      kind;
    logic [7:0] servo_id;
    logic [7:0] instruction;
    logic [7:0] address;
    logic [7:0] param_count;
    logic       has_address;
    logic [7:0] param_byte;
    bit         drain_first;
  } frame_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } bus_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic [InDataW-1:0]  in_data = '0;
  logic                in_kind = 1'b0;
  logic                out_ready = 1'b0;
  wire                 in_ready;
  wire                 out_valid;
  wire  [7:0]          out_data;
  wire                 out_last;

  frame_item_t pending_items[$];
  bus_byte_t   packet_bytes[$];
  frame_item_t on_bus;

  // Model of the framer.
  logic [7:0] pkt_sum = '0;
  logic [7:0] params_left = '0;
  logic       pkt_open = 1'b0;

  int unsigned n_sent = 0;
  int unsigned n_total = 0;
  int unsigned n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_packets = 0;
  int unsigned cycle = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  wire         calm = (n_sent >= CalmFrom) && (n_sent < CalmTo);

  servo_packet_framer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_kind),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tlast  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle, msg);
    n_errors++;
  endtask

  function automatic void push_byte(input logic [7:0] value, input logic last);
    bus_byte_t b;
    b.value = value;
    b.last  = last;
    packet_bytes.push_back(b);
  endfunction

  function automatic void close_packet();
    push_byte(~pkt_sum, 1'b1);
    pkt_open    = 1'b0;
    params_left = '0;
    pkt_sum     = '0;
  endfunction

  function automatic void frame_item(input frame_item_t it);
    logic [7:0] len;
    if (it.kind == KIND_HEADER) begin
      push_byte(SyncByte, 1'b0);
      push_byte(SyncByte, 1'b0);
      push_byte(it.servo_id, 1'b0);
      if (it.has_address) begin
        len = it.param_count + LenOffset;
        push_byte(len, 1'b0);
        push_byte(it.instruction, 1'b0);
        push_byte(it.address, 1'b0);
        pkt_sum     = it.servo_id + len + it.instruction + it.address;
        params_left = it.param_count;
        pkt_open    = 1'b1;
        if (it.param_count == 8'd0) close_packet();
      end else begin
        push_byte(BareLen, 1'b0);
        push_byte(it.instruction, 1'b0);
        pkt_sum = it.servo_id + BareLen + it.instruction;
        close_packet();
      end
    end else if (pkt_open) begin
      push_byte(it.param_byte, 1'b0);
      pkt_sum     = pkt_sum + it.param_byte;
      params_left = params_left - 8'd1;
      if (params_left == 8'd0) close_packet();
    end
  endfunction

  function automatic void add_header(input logic [7:0] id, input logic [7:0] inst,
                                     input logic [7:0] addr, input logic [7:0] count,
                                     input logic has_addr, input bit drain = 1'b0);
    frame_item_t it;
    it.kind        = KIND_HEADER;
    it.servo_id    = id;
    it.instruction = inst;
    it.address     = addr;
    it.param_count = count;
    it.has_address = has_addr;
    it.param_byte  = 8'($urandom);
    it.drain_first = drain;
    pending_items.push_back(it);
  endfunction

  function automatic void add_param(input logic [7:0] value);
    frame_item_t it;
    // Header fields carry junk in parameter items; the block must ignore them.
    it.kind        = KIND_PARAM;
    it.servo_id    = 8'($urandom);
    it.instruction = 8'($urandom);
    it.address     = 8'($urandom);
    it.param_count = 8'($urandom);
    it.has_address = 1'($urandom);
    it.param_byte  = value;
    it.drain_first = 1'b0;
    pending_items.push_back(it);
  endfunction

  // Source side: holds an item until it is taken, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_item(on_bus);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() == 0 ||
            (pending_items[0].drain_first && packet_bytes.size() != 0) ||
            (!calm && $urandom_range(0, 99) < IdlePct)) begin
          in_valid <= 1'b0;
        end else begin
          on_bus = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind  <= on_bus.kind;
          in_data  <= {7'd0, on_bus.param_byte, on_bus.has_address, on_bus.param_count,
                       on_bus.address, on_bus.instruction, on_bus.servo_id};
        end
      end
    end
  end

  // Sink readiness, with one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_sent >= HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Output checker and run limit.
  always @(posedge clk) begin
    bus_byte_t exp_b;
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle, packet_bytes.size());
      $display("TB_ERROR");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      n_bytes++;
      if (packet_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", out_data, out_last));
      end else begin
        exp_b = packet_bytes.pop_front();
        if (out_data !== exp_b.value)
          report($sformatf("byte %02h, expected %02h", out_data, exp_b.value));
        if (out_last !== exp_b.last)
          report($sformatf("last %0b, expected %0b", out_last, exp_b.last));
        if (exp_b.last) n_packets++;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned cnt;
    int unsigned sent_params;

    // Parameters while idle are dropped.
    add_param(8'hFF);
    add_param(8'h00);
    // Bare headers ignore address and count.
    add_header(8'd0, 8'd0, 8'hFF, 8'd252, 1'b0);
    add_header(8'd254, 8'hFF, 8'h00, 8'd0, 1'b0);
    // Address header with no parameters closes at once.
    add_header(8'd254, 8'd3, 8'hFF, 8'd0, 1'b1);
    add_header(8'd1, 8'd4, 8'h00, 8'd1, 1'b1);
    add_param(8'hFF);
    add_header(8'h55, 8'hAA, 8'h5A, 8'd2, 1'b1);
    add_param(8'h00);
    add_param(8'h81);
    // Counts above range wrap the length; both packets are cut short by a
    // new header, once with an address and once bare.
    add_header(8'd7, 8'd3, 8'd30, 8'd253, 1'b1);
    add_param(8'h12);
    add_param(8'h34);
    add_header(8'd2, 8'd3, 8'd40, 8'd255, 1'b1);
    add_param(8'h7F);
    add_header(8'd9, 8'd1, 8'd0, 8'd0, 1'b0);
    add_header(8'd3, 8'd3, 8'd42, 8'd3, 1'b1);
    add_param(8'hFE);
    add_param(8'h01);
    add_param(8'h80);

    // Random packets; the first waits for the directed part to drain.
    add_header(8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom),
               8'($urandom_range(0, 4)), 1'b1, 1'b1);
    cnt = pending_items[pending_items.size() - 1].param_count;
    repeat (cnt) add_param(8'($urandom));
    while (pending_items.size() < 330) begin
      sel = $urandom_range(0, 99);
      if (pending_items.size() > 150 && pending_items.size() < 160) sel = 50;
      if (sel < 12) begin
        add_header(8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom),
                   8'($urandom), 1'b0);
      end else if (sel < 82) begin
        cnt = ($urandom_range(0, 99) < 4) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        add_header(8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom), 8'(cnt), 1'b1,
                   pending_items.size() > 160 && pending_items.size() < 168);
        repeat (cnt) add_param(8'($urandom));
      end else if (sel < 92) begin
        // Broken packet: fewer parameters than announced.
        cnt = $urandom_range(2, 8);
        sent_params = $urandom_range(0, cnt - 1);
        add_header(8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom), 8'(cnt), 1'b1);
        repeat (sent_params) add_param(8'($urandom));
      end else begin
        add_param(8'($urandom));
      end
    end
    n_total = pending_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (n_sent == n_total);
    while (packet_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d items sent, %0d bytes checked, %0d packets closed with a checksum",
             n_total, n_bytes, n_packets);
    $display("covered bare, empty, short, wrapped-length and abandoned packets, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
